// ===== hdl/isacc_pkg.sv =====
`timescale 1ns / 1ps

package isacc_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int CODE_W = 8;
    localparam int STAMP_W = 32;
    localparam int STEP_W = 16;
    localparam int WIN_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_LO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_HI = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURVE = 2'd3;

    localparam logic signed [STEP_W-1:0] STEP_LO_RST = 16'sd1;
    localparam logic signed [STEP_W-1:0] STEP_HI_RST = 16'sd10;
    localparam logic [WIN_W-1:0] WINDOW_RST = 32'd500;
    localparam logic CURVE_RST = 1'b1;

    localparam logic CURVE_ZONES = 1'b0;
    localparam logic CURVE_QUAD = 1'b1;

    // zone edges in ms
    localparam int ZONE_FULL = 30;
    localparam int ZONE_3Q = 80;
    localparam int ZONE_HALF = 150;
    localparam int ZONE_1Q = 300;

    // quadratic curve clamp
    localparam int CLAMP_LO = 20;
    localparam int CLAMP_HI = 300;

    // ceil(2^24/280) and ceil(2^32/255): the rounding error stays below one
    // step of the remainder over the whole operand range, so no correction
    localparam logic [15:0] RECIP_280 = 16'd59919;
    localparam logic [24:0] RECIP_255 = 25'd16843010;

    typedef logic [255:0][7:0] q_table_t;

    function automatic q_table_t build_q_table();
        q_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'((i * i) / 255);
        end
        return t;
    endfunction

    // f*f/255 for every f
    localparam q_table_t Q_TABLE = build_q_table();

    typedef struct packed {
        logic load;
        logic calc;
        logic prod;
        logic fin;
    } isacc_cmd_t;

endpackage

// ===== hdl/input_step_acceleration_core.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: event_code, now_ms
// m_axis    out  tvalid/tready           tdata: step_out; tuser: restarted
// cfg       in   cfg_we                  cfg_addr, cfg_wdata
//
// an event runs in turn through accept, gap and zone step, curve product,
// and divide and select, each step in its own state
// the result sits in an output register, so the next event is accepted
// while it waits; a stalled output holds the following result in the last step
// reset clears history to code 0 and stamp 0 and loads the register defaults

module input_step_acceleration_core #(
    parameter int TIME_WIDTH = isacc_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [39:0]                         s_axis_tdata,   // event_code, now_ms
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,   // step_out
    output logic [0:0]                          m_axis_tuser,   // restarted
    input  logic                                cfg_we,
    input  logic [isacc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [isacc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    isacc_pkg::isacc_cmd_t cmd;
    logic signed [15:0]    step_out;
    logic                  restarted;

    isacc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    isacc_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .event_code (s_axis_tdata[7:0]),
        .now_ms     (s_axis_tdata[39:8]),
        .step_out   (step_out),
        .restarted  (restarted)
    );

    assign m_axis_tdata = step_out;
    assign m_axis_tuser = restarted;

    // no new beat is taken while an event is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready)
        |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while an event is in flight");

    // with the output register empty, the last step does not wait and the result shows
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |-> ##4 m_axis_tvalid)
    else $error("result missing after an event with free output");

    // an output beat never appears without an event having been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output beat without an event in flight");

endmodule

// ===== hdl/isacc_ctrl.sv =====
`timescale 1ns / 1ps

module isacc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output isacc_pkg::isacc_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GAP = 2'd1;
    localparam logic [1:0] ST_PROD = 2'd2;
    localparam logic [1:0] ST_FIN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_GAP;
                end
            end
            ST_GAP:
            begin
                cmd.calc = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/isacc_dp.sv =====
`timescale 1ns / 1ps

module isacc_dp #(
    parameter int TIME_WIDTH = isacc_pkg::TIME_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  isacc_pkg::isacc_cmd_t                 cmd,
    input  logic                                  cfg_we,
    input  logic [isacc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [isacc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [isacc_pkg::CODE_W-1:0]          event_code,
    input  logic [isacc_pkg::STAMP_W-1:0]         now_ms,
    output logic signed [isacc_pkg::STEP_W-1:0]   step_out,
    output logic                                  restarted
);

    // configuration
    logic signed [15:0] step_lo_reg;
    logic signed [15:0] step_hi_reg;
    logic [31:0]        window_reg;
    logic               curve_reg;

    // history
    logic [TIME_WIDTH-1:0] last_stamp_reg;
    logic [7:0]            last_code_reg;

    // input capture
    logic [7:0]            code_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    // intermediate results
    logic               restart_reg;
    logic signed [15:0] zone_reg;
    logic [7:0]         f_reg;
    logic               neg_reg;
    logic [23:0]        mag_reg;
    logic signed [15:0] step_out_reg;
    logic               restarted_reg;

    logic [TIME_WIDTH-1:0] gap;
    logic                  restart;
    logic [8:0]            g_clamp;
    logic [8:0]            inv;
    logic [16:0]           inv255;
    logic [32:0]           f_prod;
    logic signed [16:0]    span;
    logic signed [18:0]    span3;
    logic signed [18:0]    d34;
    logic signed [16:0]    d2;
    logic signed [16:0]    d4;
    logic signed [18:0]    lo19;
    logic signed [15:0]    zone_step;
    logic [7:0]            q;
    logic signed [25:0]    p;
    logic [25:0]           p_abs;
    logic [48:0]           quo_full;
    logic [15:0]           quo;
    logic signed [16:0]    curve_off;
    logic signed [15:0]    curve_step;
    logic signed [15:0]    result;

    assign gap = now_reg - last_stamp_reg;
    assign restart = (code_reg != last_code_reg) || (32'(gap) > window_reg);

    always_comb
    begin
        priority if (gap < TIME_WIDTH'(isacc_pkg::CLAMP_LO))
        begin
            g_clamp = 9'(isacc_pkg::CLAMP_LO);
        end
        else if (gap > TIME_WIDTH'(isacc_pkg::CLAMP_HI))
        begin
            g_clamp = 9'(isacc_pkg::CLAMP_HI);
        end
        else
        begin
            g_clamp = gap[8:0];
        end
    end

    assign inv = 9'(isacc_pkg::CLAMP_HI) - g_clamp;
    assign inv255 = {inv, 8'b0} - {8'b0, inv};
    // inv*255/280 by reciprocal
    assign f_prod = 33'(inv255) * 33'(isacc_pkg::RECIP_280);

    // zone steps, each quotient truncated toward zero
    assign span = {step_hi_reg[15], step_hi_reg} - {step_lo_reg[15], step_lo_reg};
    assign span3 = {{2{span[16]}}, span} + {span[16], span, 1'b0};
    assign d34 = (span3 + (span3[18] ? 19'sd3 : 19'sd0)) >>> 2;
    assign d2 = (span + (span[16] ? 17'sd1 : 17'sd0)) >>> 1;
    assign d4 = (span + (span[16] ? 17'sd3 : 17'sd0)) >>> 2;
    assign lo19 = {{3{step_lo_reg[15]}}, step_lo_reg};

    always_comb
    begin
        priority if (gap < TIME_WIDTH'(isacc_pkg::ZONE_FULL))
        begin
            zone_step = step_hi_reg;
        end
        else if (gap < TIME_WIDTH'(isacc_pkg::ZONE_3Q))
        begin
            zone_step = 16'(lo19 + d34);
        end
        else if (gap < TIME_WIDTH'(isacc_pkg::ZONE_HALF))
        begin
            zone_step = 16'(lo19 + {{2{d2[16]}}, d2});
        end
        else if (gap < TIME_WIDTH'(isacc_pkg::ZONE_1Q))
        begin
            zone_step = 16'(lo19 + {{2{d4[16]}}, d4});
        end
        else
        begin
            zone_step = step_lo_reg;
        end
    end

    // quadratic curve: span * q, then / 255 on the magnitude
    assign q = isacc_pkg::Q_TABLE[f_reg];
    assign p = {{9{span[16]}}, span} * $signed({18'b0, q});
    assign p_abs = p[25] ? 26'(-p) : 26'(p);

    assign quo_full = 49'(mag_reg) * 49'(isacc_pkg::RECIP_255);
    assign quo = quo_full[47:32];
    assign curve_off = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign curve_step = 16'({step_lo_reg[15], step_lo_reg} + curve_off);

    always_comb
    begin
        priority if (restart_reg)
        begin
            result = step_lo_reg;
        end
        else if (curve_reg == isacc_pkg::CURVE_ZONES)
        begin
            result = zone_reg;
        end
        else
        begin
            result = curve_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_lo_reg <= isacc_pkg::STEP_LO_RST;
            step_hi_reg <= isacc_pkg::STEP_HI_RST;
            window_reg <= isacc_pkg::WINDOW_RST;
            curve_reg <= isacc_pkg::CURVE_RST;
            last_stamp_reg <= '0;
            last_code_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    isacc_pkg::CFG_STEP_LO:  step_lo_reg <= cfg_wdata[15:0];
                    isacc_pkg::CFG_STEP_HI:  step_hi_reg <= cfg_wdata[15:0];
                    isacc_pkg::CFG_WINDOW:   window_reg <= cfg_wdata;
                    isacc_pkg::CFG_CURVE:    curve_reg <= cfg_wdata[0];
                    default:                 curve_reg <= curve_reg;
                endcase
            end
            if (cmd.calc)
            begin
                last_stamp_reg <= now_reg;
                last_code_reg <= code_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= event_code;
            now_reg <= now_ms[TIME_WIDTH-1:0];
        end
        if (cmd.calc)
        begin
            restart_reg <= restart;
            zone_reg <= zone_step;
            f_reg <= f_prod[31:24];
        end
        if (cmd.prod)
        begin
            neg_reg <= p[25];
            mag_reg <= p_abs[23:0];
        end
        if (cmd.fin)
        begin
            step_out_reg <= result;
            restarted_reg <= restart_reg;
        end
    end

    assign step_out = step_out_reg;
    assign restarted = restarted_reg;

endmodule
